### rtl/aae_pkg.sv
`timescale 1ns / 1ps
// aae_pkg: shared constants, command and status types for the adaptive
// arithmetic encoder; no dependencies
package aae_pkg;

    localparam int REG_BITS     = 16;
    localparam int FOLLOW_LIMIT = 255;
    localparam int NSYM         = 258;
    localparam int END_SYM      = 257;
    localparam int MAX_OUT      = 40;
    localparam int SYM_W        = 9;
    localparam int CNT_W        = 15;
    localparam int OBUF_W       = 6;
    localparam int THR_W        = 14;

    localparam logic [REG_BITS-1:0] TOP_VAL = 16'hFFFF;
    localparam logic [REG_BITS-1:0] QTR1    = 16'h4000;
    localparam logic [REG_BITS-1:0] HALF_V  = 16'h8000;
    localparam logic [REG_BITS-1:0] QTR3    = 16'hC000;
    localparam logic [THR_W-1:0]    THRESH_RESET = 14'd16383;
    localparam logic [5:0]          GUARD_MAX    = 6'd32;

    // datapath operations
    localparam logic [4:0] OP_NONE   = 5'd0;
    localparam logic [4:0] OP_CLR    = 5'd1;
    localparam logic [4:0] OP_ACC    = 5'd2;
    localparam logic [4:0] OP_LOOK   = 5'd3;
    localparam logic [4:0] OP_LOOKC  = 5'd4;
    localparam logic [4:0] OP_RC0    = 5'd5;
    localparam logic [4:0] OP_RC1    = 5'd6;
    localparam logic [4:0] OP_RC2    = 5'd7;
    localparam logic [4:0] OP_RC3    = 5'd8;
    localparam logic [4:0] OP_DIVS_A = 5'd9;
    localparam logic [4:0] OP_DIVS_B = 5'd10;
    localparam logic [4:0] OP_DIV    = 5'd11;
    localparam logic [4:0] OP_DIVF_A = 5'd12;
    localparam logic [4:0] OP_DIVF_B = 5'd13;
    localparam logic [4:0] OP_REN    = 5'd14;
    localparam logic [4:0] OP_FOL    = 5'd15;
    localparam logic [4:0] OP_EFOL   = 5'd16;
    localparam logic [4:0] OP_EBIT   = 5'd17;
    localparam logic [4:0] OP_EFIN   = 5'd18;
    localparam logic [4:0] OP_ACHK   = 5'd19;
    localparam logic [4:0] OP_RS     = 5'd20;
    localparam logic [4:0] OP_F0     = 5'd21;
    localparam logic [4:0] OP_F1     = 5'd22;
    localparam logic [4:0] OP_F2     = 5'd23;
    localparam logic [4:0] OP_SW0    = 5'd24;
    localparam logic [4:0] OP_SW1    = 5'd25;
    localparam logic [4:0] OP_SW2    = 5'd26;
    localparam logic [4:0] OP_INC0   = 5'd27;
    localparam logic [4:0] OP_INC    = 5'd28;
    localparam logic [4:0] OP_DR0    = 5'd29;
    localparam logic [4:0] OP_DR1    = 5'd30;
    localparam logic [4:0] OP_DR2    = 5'd31;

    // renormalization cases
    localparam logic [1:0] REN_NONE = 2'd0;
    localparam logic [1:0] REN_E1   = 2'd1;
    localparam logic [1:0] REN_E2   = 2'd2;
    localparam logic [1:0] REN_E3   = 2'd3;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       div_last;
        logic [1:0] ren_code;
        logic       guard_max;
        logic       pend_nz;
        logic       pend_one;
        logic       resc;
        logic       sw_run;
        logic       pv;
        logic       s_gt1;
        logic       feq;
        logic       idx_gt2;
        logic       i_lt_s;
        logic       cnt_nz;
        logic       kind;
        logic       taken;
        logic       drain_last;
    } status_t;

endpackage

### rtl/adaptive_arith_encoder_top.sv
`timescale 1ns / 1ps
// adaptive_arith_encoder_top: adaptive arithmetic encoder, 16-bit interval
// depends on aae_pkg, aae_ctrl, aae_dp (which uses aae_ram)
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | kind, data_byte
//  output   | out_valid/ out_stall | out_byte, last_of_run, stream_done,
//           |                      | follow_overflow
//  config   | cfg_valid/ cfg_ready | cfg_data (rescale threshold)
//
// one item at a time: coding (two 32-step dividers), the cumulative-count
// update (one entry per cycle, up to 256), a rescale sweep (258 entries) when
// the total reaches the threshold, and a read, present and wait-for-accept
// per result beat; the tables' single read and write ports set the pace
// after reset and after each end mark a clearing pass over all 258 entries
// restores the tables; no input is taken then, config writes are taken always
// results are buffered and delivered after the item's coding ends, so a
// stall on the output simply holds the current beat
module adaptive_arith_encoder_top
    import aae_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [7:0]       data_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             stream_done,
    output logic             follow_overflow,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    // threshold register always takes a write
    assign cfg_ready = 1'b1;

    // sequencer
    aae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // coder datapath with tables and result buffer
    aae_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (kind),
        .data_byte       (data_byte),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .st              (st),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .stream_done     (stream_done),
        .follow_overflow (follow_overflow)
    );

endmodule

### rtl/aae_ram.sv
`timescale 1ns / 1ps
// aae_ram: generic single write, single read ram with registered read data
// no dependencies
module aae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/aae_ctrl.sv
`timescale 1ns / 1ps
// aae_ctrl: sequencer for the encoder; issues datapath operations
// depends on aae_pkg
module aae_ctrl
    import aae_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t st,
    output logic    in_stall,
    output cmd_t    cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_LOOK  = 5'd2;
    localparam logic [4:0] S_LOOKC = 5'd3;
    localparam logic [4:0] S_RC0   = 5'd4;
    localparam logic [4:0] S_RC1   = 5'd5;
    localparam logic [4:0] S_RC2   = 5'd6;
    localparam logic [4:0] S_RC3   = 5'd7;
    localparam logic [4:0] S_D1S   = 5'd8;
    localparam logic [4:0] S_D1    = 5'd9;
    localparam logic [4:0] S_D1F   = 5'd10;
    localparam logic [4:0] S_D2S   = 5'd11;
    localparam logic [4:0] S_D2    = 5'd12;
    localparam logic [4:0] S_D2F   = 5'd13;
    localparam logic [4:0] S_REN   = 5'd14;
    localparam logic [4:0] S_FOL   = 5'd15;
    localparam logic [4:0] S_EFOL  = 5'd16;
    localparam logic [4:0] S_EBIT  = 5'd17;
    localparam logic [4:0] S_EFFOL = 5'd18;
    localparam logic [4:0] S_EFIN  = 5'd19;
    localparam logic [4:0] S_ACHK  = 5'd20;
    localparam logic [4:0] S_RS    = 5'd21;
    localparam logic [4:0] S_F0    = 5'd22;
    localparam logic [4:0] S_F1    = 5'd23;
    localparam logic [4:0] S_F2    = 5'd24;
    localparam logic [4:0] S_SWC   = 5'd25;
    localparam logic [4:0] S_SW0   = 5'd26;
    localparam logic [4:0] S_SW1   = 5'd27;
    localparam logic [4:0] S_SW2   = 5'd28;
    localparam logic [4:0] S_INC0  = 5'd29;
    localparam logic [4:0] S_INC   = 5'd30;
    localparam logic [4:0] S_DR    = 5'd31;

    logic [4:0] state_reg, state_next;
    logic [1:0] dph_reg, dph_next;   // drain phase

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            dph_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            dph_reg   <= dph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dph_next   = dph_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLR;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_ACC;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (st.kind)
                    state_next = S_RC0;
                else
                begin
                    cmd.op = OP_LOOK;
                    state_next = S_LOOKC;
                end
            end
            S_LOOKC:
            begin
                cmd.op = OP_LOOKC;
                state_next = S_RC0;
            end
            S_RC0:
            begin
                cmd.op = OP_RC0;
                state_next = S_RC1;
            end
            S_RC1:
            begin
                cmd.op = OP_RC1;
                state_next = S_RC2;
            end
            S_RC2:
            begin
                cmd.op = OP_RC2;
                state_next = S_RC3;
            end
            S_RC3:
            begin
                cmd.op = OP_RC3;
                state_next = S_D1S;
            end
            S_D1S:
            begin
                cmd.op = OP_DIVS_A;
                state_next = S_D1;
            end
            S_D1:
            begin
                cmd.op = OP_DIV;
                if (st.div_last)
                    state_next = S_D1F;
            end
            S_D1F:
            begin
                cmd.op = OP_DIVF_A;
                state_next = S_D2S;
            end
            S_D2S:
            begin
                cmd.op = OP_DIVS_B;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.op = OP_DIV;
                if (st.div_last)
                    state_next = S_D2F;
            end
            S_D2F:
            begin
                cmd.op = OP_DIVF_B;
                state_next = S_REN;
            end
            S_REN:
            begin
                cmd.op = OP_REN;
                if (st.guard_max || st.ren_code == REN_NONE)
                    state_next = st.kind ? S_EFOL : S_ACHK;
                else if ((st.ren_code == REN_E1 || st.ren_code == REN_E2) && st.pend_nz)
                    state_next = S_FOL;
            end
            S_FOL:
            begin
                cmd.op = OP_FOL;
                if (st.pend_one)
                    state_next = S_REN;
            end
            S_EFOL:
            begin
                cmd.op = OP_EFOL;
                state_next = S_EBIT;
            end
            S_EBIT:
            begin
                cmd.op = OP_EBIT;
                state_next = st.pend_nz ? S_EFFOL : S_EFIN;
            end
            S_EFFOL:
            begin
                cmd.op = OP_FOL;
                if (st.pend_one)
                    state_next = S_EFIN;
            end
            S_EFIN:
            begin
                cmd.op = OP_EFIN;
                state_next = S_DR;
                dph_next = 2'd0;
            end
            S_ACHK:
            begin
                cmd.op = OP_ACHK;
                state_next = st.resc ? S_RS : S_F0;
            end
            S_RS:
            begin
                cmd.op = OP_RS;
                if (!st.sw_run && st.pv)
                    state_next = S_F0;
            end
            S_F0:
            begin
                cmd.op = OP_F0;
                state_next = S_F1;
            end
            S_F1:
            begin
                cmd.op = OP_F1;
                state_next = st.s_gt1 ? S_F2 : S_SWC;
            end
            S_F2:
            begin
                cmd.op = OP_F2;
                if (!(st.feq && st.idx_gt2))
                    state_next = S_SWC;
            end
            S_SWC:
            begin
                state_next = st.i_lt_s ? S_SW0 : S_INC0;
            end
            S_SW0:
            begin
                cmd.op = OP_SW0;
                state_next = S_SW1;
            end
            S_SW1:
            begin
                cmd.op = OP_SW1;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                cmd.op = OP_SW2;
                state_next = S_INC0;
            end
            S_INC0:
            begin
                cmd.op = OP_INC0;
                state_next = S_INC;
            end
            S_INC:
            begin
                cmd.op = OP_INC;
                if (!st.sw_run && st.pv)
                begin
                    state_next = st.cnt_nz ? S_DR : S_IDLE;
                    dph_next = 2'd0;
                end
            end
            S_DR:
            begin
                case (dph_reg)
                    2'd0:
                    begin
                        cmd.op = OP_DR0;
                        dph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        cmd.op = OP_DR1;
                        dph_next = 2'd2;
                    end
                    default:
                    begin
                        cmd.op = OP_DR2;
                        if (st.taken)
                        begin
                            dph_next = 2'd0;
                            if (st.drain_last)
                                state_next = st.kind ? S_CLEAR : S_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

### rtl/aae_dp.sv
`timescale 1ns / 1ps
// aae_dp: interval registers, divider, packer, model tables and output buffer
// depends on aae_pkg and aae_ram
module aae_dp
    import aae_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             kind,
    input  logic [7:0]       data_byte,
    input  logic             cfg_valid,
    input  logic [THR_W-1:0] cfg_data,
    input  logic             out_stall,
    output status_t          st,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             stream_done,
    output logic             follow_overflow
);

    logic [REG_BITS-1:0] low_reg, high_reg, hi_new_reg;
    logic [7:0]          pend_reg, pack_reg, byte_reg, bi_reg, ob_reg;
    logic [3:0]          left_reg;
    logic                ovf_reg, kind_reg, fbit_reg, ov_reg, sw_run_reg, pv_reg;
    logic [SYM_W-1:0]    sym_reg, idx_reg, j_reg, pj_reg;
    logic [CNT_W-1:0]    cum_a_reg, cum_b_reg, tot_reg, acc_reg, fs_reg;
    logic [16:0]         range_reg;
    logic [31:0]         num_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [5:0]          dcnt_reg, guard_reg;
    logic [OBUF_W-1:0]   cnt_reg, k_reg;
    logic [THR_W-1:0]    thr_reg;

    // ram ports
    logic                fq_we, cf_we, ib_we, bi_we, ob_we;
    logic [SYM_W-1:0]    fq_wa, fq_ra, cf_wa, cf_ra, ib_wa, ib_ra;
    logic [CNT_W-1:0]    fq_wd, fq_rd, cf_wd, cf_rd;
    logic [7:0]          ib_wd, ib_rd, bi_ra, bi_wa, ob_wd, ob_rd;
    logic [SYM_W-1:0]    bi_wd, bi_rd;
    logic [OBUF_W-1:0]   ob_wa, ob_ra;

    aae_ram #(.WIDTH(CNT_W), .DEPTH(NSYM)) u_freq (
        .clk(clk), .we(fq_we), .waddr(fq_wa), .wdata(fq_wd), .raddr(fq_ra), .rdata(fq_rd));
    aae_ram #(.WIDTH(CNT_W), .DEPTH(NSYM)) u_cum (
        .clk(clk), .we(cf_we), .waddr(cf_wa), .wdata(cf_wd), .raddr(cf_ra), .rdata(cf_rd));
    aae_ram #(.WIDTH(8), .DEPTH(NSYM)) u_i2b (
        .clk(clk), .we(ib_we), .waddr(ib_wa), .wdata(ib_wd), .raddr(ib_ra), .rdata(ib_rd));
    aae_ram #(.WIDTH(SYM_W), .DEPTH(256)) u_b2i (
        .clk(clk), .we(bi_we), .waddr(bi_wa), .wdata(bi_wd), .raddr(bi_ra), .rdata(bi_rd));
    aae_ram #(.WIDTH(8), .DEPTH(MAX_OUT)) u_obuf (
        .clk(clk), .we(ob_we), .waddr(ob_wa), .wdata(ob_wd), .raddr(ob_ra), .rdata(ob_rd));

    // renormalization decision
    logic [1:0] ren_code;
    always_comb
    begin
        if (high_reg < HALF_V)
            ren_code = REN_E1;
        else if (low_reg >= HALF_V)
            ren_code = REN_E2;
        else if (low_reg >= QTR1 && high_reg < QTR3)
            ren_code = REN_E3;
        else
            ren_code = REN_NONE;
    end

    // packer bit source for this cycle
    logic       pb_en, pb_val;
    logic [7:0] pack_new;
    logic       pb_full;
    always_comb
    begin
        pb_en  = 1'b0;
        pb_val = 1'b0;
        case (cmd.op)
            OP_REN:
            begin
                pb_en  = !(guard_reg == GUARD_MAX) &&
                         (ren_code == REN_E1 || ren_code == REN_E2);
                pb_val = (ren_code == REN_E2);
            end
            OP_FOL:
            begin
                pb_en  = 1'b1;
                pb_val = !fbit_reg;
            end
            OP_EBIT:
            begin
                pb_en  = 1'b1;
                pb_val = (low_reg >= QTR1);
            end
            default:
            begin
                pb_en = 1'b0;
            end
        endcase
        pack_new = {pb_val, pack_reg[7:1]};
        pb_full  = pb_en && (left_reg == 4'd1);
    end

    // divider step
    logic [CNT_W-1:0] tot_eff;
    logic [CNT_W:0]   dtry;
    logic             dge;
    assign tot_eff = (tot_reg == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : tot_reg;
    assign dtry    = {rem_reg, num_reg[31]};
    assign dge     = (dtry >= {1'b0, tot_eff});

    logic [OBUF_W-1:0] fin_pos;
    logic [CNT_W:0]    half_f;
    logic [7:0]        fin_byte;
    logic [SYM_W-1:0]  sym_m1, idx_m1, idx_m2;
    logic [REG_BITS:0] low_add_q;
    assign fin_pos   = (cnt_reg >= OBUF_W'(MAX_OUT)) ? OBUF_W'(MAX_OUT - 1) : cnt_reg;
    assign half_f    = ({1'b0, fq_rd} + 1'b1) >> 1;
    assign fin_byte  = 8'(({8'd0, pack_reg} >> left_reg));
    assign sym_m1    = sym_reg - 1'b1;
    assign idx_m1    = idx_reg - 1'b1;
    assign idx_m2    = idx_reg - 2'd2;
    assign low_add_q = {1'b0, low_reg} + num_reg[REG_BITS:0];

    // ram control
    always_comb
    begin
        fq_we = 1'b0; fq_wa = pj_reg; fq_wd = '0; fq_ra = j_reg;
        cf_we = 1'b0; cf_wa = pj_reg; cf_wd = '0; cf_ra = j_reg;
        ib_we = 1'b0; ib_wa = j_reg;  ib_wd = '0; ib_ra = idx_reg;
        bi_we = 1'b0; bi_wa = j_reg[7:0]; bi_wd = '0; bi_ra = byte_reg;
        ob_we = 1'b0; ob_wa = cnt_reg; ob_wd = pack_new; ob_ra = k_reg;
        if (pb_full && cnt_reg < OBUF_W'(MAX_OUT))
            ob_we = 1'b1;
        case (cmd.op)
            OP_CLR:
            begin
                fq_we = 1'b1; fq_wa = j_reg;
                fq_wd = (j_reg == '0) ? '0 : {{(CNT_W-1){1'b0}}, 1'b1};
                cf_we = 1'b1; cf_wa = j_reg;
                cf_wd = CNT_W'(END_SYM) - CNT_W'(j_reg);
                ib_we = 1'b1;
                ib_wd = (j_reg >= 9'd1 && j_reg <= 9'd256) ? 8'(j_reg - 1'b1) : 8'd0;
                bi_we = !j_reg[8];
                bi_wd = j_reg + 1'b1;
            end
            OP_RC0:  cf_ra = sym_m1;
            OP_RC1:  cf_ra = sym_reg;
            OP_RC2:  cf_ra = '0;
            OP_EFIN:
            begin
                ob_we = 1'b1; ob_wa = fin_pos; ob_wd = fin_byte;
            end
            OP_RS:
            begin
                fq_we = pv_reg; fq_wd = half_f[CNT_W-1:0];
                cf_we = pv_reg; cf_wd = acc_reg;
            end
            OP_F0:   fq_ra = sym_reg;
            OP_F1:   fq_ra = sym_m1;
            OP_F2:   fq_ra = idx_m2;
            OP_SW1:
            begin
                ib_we = 1'b1; ib_wa = idx_reg; ib_wd = byte_reg;
                bi_we = 1'b1; bi_wa = ib_rd; bi_wd = sym_reg;
            end
            OP_SW2:
            begin
                ib_we = 1'b1; ib_wa = sym_reg; ib_wd = bi_reg;
                bi_we = 1'b1; bi_wa = byte_reg; bi_wd = idx_reg;
            end
            OP_INC0:
            begin
                fq_we = 1'b1; fq_wa = idx_reg; fq_wd = fs_reg + 1'b1;
            end
            OP_INC:
            begin
                cf_we = pv_reg; cf_wd = cf_rd + 1'b1;
            end
            default:
            begin
                fq_we = 1'b0;
            end
        endcase
    end

    // status
    always_comb
    begin
        st.clr_last   = (j_reg == SYM_W'(NSYM - 1));
        st.div_last   = (dcnt_reg == 6'd31);
        st.ren_code   = ren_code;
        st.guard_max  = (guard_reg == GUARD_MAX);
        st.pend_nz    = (pend_reg != 8'd0);
        st.pend_one   = (pend_reg == 8'd1);
        st.resc       = (tot_reg >= {1'b0, thr_reg});
        st.sw_run     = sw_run_reg;
        st.pv         = pv_reg;
        st.s_gt1      = (sym_reg > 9'd1);
        st.feq        = (fq_rd == fs_reg);
        st.idx_gt2    = (idx_reg > 9'd2);
        st.i_lt_s     = (idx_reg < sym_reg);
        st.cnt_nz     = (cnt_reg != '0);
        st.kind       = kind_reg;
        st.taken      = out_valid && !out_stall;
        st.drain_last = (k_reg == cnt_reg - 1'b1);
    end

    assign out_valid       = ov_reg;
    assign out_byte        = ob_reg;
    assign last_of_run     = (k_reg == cnt_reg - 1'b1);
    assign stream_done     = kind_reg && last_of_run;
    assign follow_overflow = ovf_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= '0;
            high_reg   <= TOP_VAL;
            pend_reg   <= '0;
            pack_reg   <= '0;
            left_reg   <= 4'd8;
            ovf_reg    <= 1'b0;
            kind_reg   <= 1'b0;
            j_reg      <= '0;
            sw_run_reg <= 1'b0;
            pv_reg     <= 1'b0;
            dcnt_reg   <= '0;
            guard_reg  <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            ov_reg     <= 1'b0;
            thr_reg    <= THRESH_RESET;
        end
        else
        begin
            if (cfg_valid)
                thr_reg <= cfg_data;
            if (pb_en)
            begin
                pack_reg <= pack_new;
                left_reg <= pb_full ? 4'd8 : left_reg - 1'b1;
                if (pb_full && cnt_reg < OBUF_W'(MAX_OUT))
                    cnt_reg <= cnt_reg + 1'b1;
            end
            case (cmd.op)
                OP_CLR:
                begin
                    low_reg  <= '0;
                    high_reg <= TOP_VAL;
                    pend_reg <= '0;
                    pack_reg <= '0;
                    left_reg <= 4'd8;
                    ovf_reg  <= 1'b0;
                    j_reg    <= st.clr_last ? '0 : j_reg + 1'b1;
                end
                OP_ACC:
                begin
                    kind_reg  <= kind;
                    cnt_reg   <= '0;
                    k_reg     <= '0;
                    guard_reg <= '0;
                end
                OP_DIVS_A, OP_DIVS_B:
                    dcnt_reg <= '0;
                OP_DIV:
                    dcnt_reg <= dcnt_reg + 1'b1;
                OP_REN:
                begin
                    if (!st.guard_max && ren_code != REN_NONE)
                    begin
                        guard_reg <= guard_reg + 1'b1;
                        if (ren_code == REN_E3)
                        begin
                            if (pend_reg >= 8'(FOLLOW_LIMIT))
                                ovf_reg <= 1'b1;
                            else
                                pend_reg <= pend_reg + 1'b1;
                            low_reg  <= {low_reg[14:0] - QTR1[14:0], 1'b0};
                            high_reg <= {high_reg[14:0] - QTR1[14:0], 1'b1};
                        end
                        else
                        begin
                            low_reg  <= {low_reg[14:0], 1'b0};
                            high_reg <= {high_reg[14:0], 1'b1};
                        end
                    end
                end
                OP_FOL:
                    pend_reg <= pend_reg - 1'b1;
                OP_EFOL:
                begin
                    if (pend_reg >= 8'(FOLLOW_LIMIT))
                        ovf_reg <= 1'b1;
                    else
                        pend_reg <= pend_reg + 1'b1;
                end
                OP_DIVF_B:
                begin
                    low_reg  <= low_add_q[REG_BITS-1:0];
                    high_reg <= hi_new_reg;
                end
                OP_EFIN:
                begin
                    cnt_reg <= fin_pos + 1'b1;
                    j_reg   <= '0;
                end
                OP_ACHK:
                begin
                    j_reg      <= SYM_W'(NSYM - 1);
                    sw_run_reg <= 1'b1;
                    pv_reg     <= 1'b0;
                end
                OP_RS:
                begin
                    pv_reg <= sw_run_reg;
                    if (sw_run_reg)
                    begin
                        if (j_reg == '0)
                            sw_run_reg <= 1'b0;
                        else
                            j_reg <= j_reg - 1'b1;
                    end
                end
                OP_INC0:
                begin
                    j_reg      <= '0;
                    sw_run_reg <= 1'b1;
                    pv_reg     <= 1'b0;
                end
                OP_INC:
                begin
                    pv_reg <= sw_run_reg;
                    if (sw_run_reg)
                    begin
                        if (j_reg == idx_m1)
                            sw_run_reg <= 1'b0;
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                end
                OP_DR1:
                    ov_reg <= 1'b1;
                OP_DR2:
                begin
                    if (st.taken)
                    begin
                        ov_reg <= 1'b0;
                        k_reg  <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    ov_reg <= ov_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pb_en)
            fbit_reg <= (cmd.op == OP_FOL) ? fbit_reg : pb_val;
        pj_reg <= j_reg;
        case (cmd.op)
            OP_ACC:
            begin
                byte_reg <= data_byte;
                sym_reg  <= SYM_W'(END_SYM);
            end
            OP_LOOKC: sym_reg   <= bi_rd;
            OP_RC1:   cum_a_reg <= cf_rd;
            OP_RC2:   cum_b_reg <= cf_rd;
            OP_RC3:
            begin
                tot_reg   <= cf_rd;
                range_reg <= {1'b0, high_reg} - {1'b0, low_reg} + 1'b1;
            end
            OP_DIVS_A:
            begin
                num_reg <= range_reg * cum_a_reg;
                rem_reg <= '0;
            end
            OP_DIVS_B:
            begin
                num_reg <= range_reg * cum_b_reg;
                rem_reg <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= dge ? CNT_W'(dtry - {1'b0, tot_eff}) : dtry[CNT_W-1:0];
                num_reg <= {num_reg[30:0], dge};
            end
            OP_DIVF_A: hi_new_reg <= REG_BITS'(low_add_q - 1'b1);
            OP_ACHK:   acc_reg    <= '0;
            OP_RS:
            begin
                if (pv_reg)
                    acc_reg <= acc_reg + half_f[CNT_W-1:0];
            end
            OP_F1:
            begin
                fs_reg  <= fq_rd;
                idx_reg <= sym_reg;
            end
            OP_F2:
            begin
                if (st.feq)
                    idx_reg <= idx_m1;
            end
            OP_SW1:   bi_reg <= ib_rd;
            OP_DR1:   ob_reg <= ob_rd;
            default:
            begin
                bi_reg <= bi_reg;
            end
        endcase
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for adaptive_arith_encoder_top with random idling
// depends on aae_pkg and the encoder rtl; holds its own model of the coder
module tb;
    import aae_pkg::*;

    // one expected output beat
    typedef struct {
        logic [7:0] code_byte;
        logic       item_last;
        logic       end_flag;
        logic       ovf_flag;
    } coded_beat_t;

    // coder model plus the queue of beats it predicts
    class coded_byte_board;
        coded_beat_t   want_q[$];
        int            errors;
        int            threshold;
        // model state
        longint        lo_reg;
        longint        hi_reg;
        int            follow_cnt;
        int            pack_reg;
        int            pack_left;
        bit            ovf_sticky;
        int            freq[NSYM];
        int            cum[NSYM];
        int            sym_byte[NSYM];
        int            byte_sym[256];
        int            step_bytes[$];

        function new();
            errors    = 0;
            threshold = THRESH_RESET;
            clear_model();
        endfunction

        function void clear_model();
            lo_reg     = 0;
            hi_reg     = TOP_VAL;
            follow_cnt = 0;
            pack_reg   = 0;
            pack_left  = 8;
            ovf_sticky = 0;
            for (int i = 0; i < 256; i++)
                byte_sym[i] = i + 1;
            for (int i = 0; i < NSYM; i++)
            begin
                sym_byte[i] = (i >= 1 && i <= 256) ? i - 1 : 0;
                freq[i]     = 1;
                cum[i]      = 257 - i;
            end
            freq[0] = 0;
        endfunction

        function void push_bit(int b);
            pack_reg = ((pack_reg >> 1) | (b ? 'h80 : 0)) & 'hFF;
            pack_left--;
            if (pack_left == 0)
            begin
                if (step_bytes.size() < MAX_OUT)
                    step_bytes.push_back(pack_reg);
                pack_left = 8;
            end
        endfunction

        function void push_bit_follow(int b);
            push_bit(b);
            while (follow_cnt > 0)
            begin
                push_bit(b ? 0 : 1);
                follow_cnt--;
            end
        endfunction

        function void bump_follow();
            if (follow_cnt >= FOLLOW_LIMIT)
                ovf_sticky = 1;
            else
                follow_cnt++;
        endfunction

        function void narrow(int s);
            longint span;
            longint total;
            longint base;
            span  = hi_reg - lo_reg + 1;
            total = (cum[0] != 0) ? cum[0] : 1;
            base  = lo_reg;
            hi_reg = (base + span * cum[s-1] / total - 1) & 'hFFFF;
            lo_reg = (base + span * cum[s] / total) & 'hFFFF;
            for (int g = 0; g < 2 * REG_BITS; g++)
            begin
                if (hi_reg < HALF_V)
                    push_bit_follow(0);
                else if (lo_reg >= HALF_V)
                begin
                    push_bit_follow(1);
                    lo_reg -= HALF_V;
                    hi_reg -= HALF_V;
                end
                else if (lo_reg >= QTR1 && hi_reg < QTR3)
                begin
                    bump_follow();
                    lo_reg -= QTR1;
                    hi_reg -= QTR1;
                end
                else
                    break;
                lo_reg = (lo_reg << 1) & 'hFFFF;
                hi_reg = ((hi_reg << 1) | 1) & 'hFFFF;
            end
        endfunction

        function void update_counts(int s);
            int acc;
            int i;
            int bi;
            int bs;
            if (cum[0] >= threshold)
            begin
                acc = 0;
                for (int j = NSYM - 1; j >= 0; j--)
                begin
                    freq[j] = (freq[j] + 1) / 2;
                    cum[j]  = acc;
                    acc    += freq[j];
                end
            end
            i = s;
            while (i > 1 && freq[i] == freq[i-1])
                i--;
            if (i < s)
            begin
                bi = sym_byte[i];
                bs = sym_byte[s];
                sym_byte[i] = bs;
                sym_byte[s] = bi;
                byte_sym[bi] = s;
                byte_sym[bs] = i;
            end
            freq[i]++;
            for (int j = 0; j < i; j++)
                cum[j]++;
        endfunction

        // accepted input beat: work out the beats it causes
        function void note_input(logic k, logic [7:0] b);
            bit          done;
            coded_beat_t bt;
            done = 0;
            step_bytes.delete();
            if (k == 1'b0)
            begin
                narrow(byte_sym[b]);
                update_counts(byte_sym[b]);
            end
            else
            begin
                narrow(END_SYM);
                bump_follow();
                push_bit_follow(lo_reg < QTR1 ? 0 : 1);
                while (step_bytes.size() >= MAX_OUT)
                    void'(step_bytes.pop_back());
                step_bytes.push_back((pack_reg >> pack_left) & 'hFF);
                done = 1;
            end
            foreach (step_bytes[n])
            begin
                bt.code_byte = step_bytes[n][7:0];
                bt.item_last = (n == step_bytes.size() - 1);
                bt.end_flag  = done && (n == step_bytes.size() - 1);
                bt.ovf_flag  = ovf_sticky;
                want_q.push_back(bt);
            end
            if (done)
                clear_model();
        endfunction

        // accepted output beat against the oldest expectation
        function void check_result(logic [7:0] ob, logic lr, logic sd, logic fo);
            coded_beat_t w;
            if (want_q.size() == 0)
            begin
                $display("%0t: unexpected beat out_byte=%02h", $time, ob);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (ob !== w.code_byte)
            begin
                $display("%0t: out_byte exp %02h got %02h", $time, w.code_byte, ob);
                errors++;
            end
            if (lr !== w.item_last)
            begin
                $display("%0t: last_of_run exp %0b got %0b", $time, w.item_last, lr);
                errors++;
            end
            if (sd !== w.end_flag)
            begin
                $display("%0t: stream_done exp %0b got %0b", $time, w.end_flag, sd);
                errors++;
            end
            if (fo !== w.ovf_flag)
            begin
                $display("%0t: follow_overflow exp %0b got %0b", $time, w.ovf_flag, fo);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_WAIT = 1500;   // covers an item that yields no beat
    localparam int STALL_LIMIT = 20000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             kind;
    logic [7:0]       data_byte;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       out_byte;
    logic             last_of_run;
    logic             stream_done;
    logic             follow_overflow;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;

    coded_byte_board board;
    int              quiet_cycles;
    int              stall_left;

    adaptive_arith_encoder_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .stream_done     (stream_done),
        .follow_overflow (follow_overflow),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // mostly short gaps, some long ones, and runs with none at all
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // output side: check every accepted beat, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(out_byte, last_of_run, stream_done, follow_overflow);
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no beat moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one input beat, with a random gap in front of it
    task automatic send_item(logic k, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(k, b);
    endtask

    // drain all expected beats, then let a beat-less item finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.want_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.threshold = v;
    endtask

    // random stream: skewed bytes so swaps and rescales happen, end marks between
    task automatic random_phase(int n);
        int run_left;
        int r;
        run_left = $urandom_range(3, 30);
        for (int i = 0; i < n; i++)
        begin
            if (run_left == 0)
            begin
                send_item(1'b1, 8'($urandom));
                run_left = $urandom_range(3, 30);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    send_item(1'b0, 8'($urandom_range(0, 5)));
                else
                    send_item(1'b0, 8'($urandom));
                run_left--;
            end
        end
        send_item(1'b1, 8'($urandom));
    endtask

    initial
    begin
        board        = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = 1'b0;
        data_byte    = 8'd0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        quiet_cycles = 0;
        stall_left   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: upper threshold, byte extremes, ties and repeats, end marks
        write_threshold(14'd16383);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h55);
        send_item(1'b0, 8'hAA);
        repeat (6) send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h7F);
        send_item(1'b1, 8'hFF);
        // end mark on an empty stream
        send_item(1'b1, 8'h00);
        repeat (4) send_item(1'b0, 8'h01);
        send_item(1'b1, 8'h5A);
        settle();

        // lowest in-range threshold: rescale on almost every update
        write_threshold(14'd258);
        repeat (8) send_item(1'b0, 8'h03);
        send_item(1'b1, 8'h00);
        random_phase(40);
        settle();

        // threshold below range
        write_threshold(14'd0);
        random_phase(35);
        settle();

        write_threshold(14'($urandom_range(300, 2000)));
        random_phase(40);
        settle();

        write_threshold(14'($urandom_range(2001, 16382)));
        random_phase(35);
        settle();

        write_threshold(14'd16383);
        random_phase(50);
        settle();

        if (board.errors == 0 && board.want_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### files.f
rtl/aae_pkg.sv
rtl/aae_ram.sv
rtl/aae_ctrl.sv
rtl/aae_dp.sv
rtl/adaptive_arith_encoder_top.sv
bench/tb.sv
